FILE: sv/shunting_yard_rpn_converter_macros.svh
// assertion macros for the rpn converter module
`ifndef SHUNTING_YARD_RPN_CONVERTER_MACROS_SVH
`define SHUNTING_YARD_RPN_CONVERTER_MACROS_SVH

// condition holds in every cycle out of reset
`define SYR_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SYR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SYR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/syr_pkg.sv
package syr_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int REF_W           = 16;
    localparam int PREC_W          = 2;
    localparam int ARITY_W         = 6;

    typedef enum logic [3:0] {
        TK_NUM     = 4'd0,
        TK_OPEN    = 4'd1,
        TK_CLOSE   = 4'd2,
        TK_OPER    = 4'd3,
        TK_FUNC    = 4'd4,
        TK_VAR     = 4'd5,
        TK_COMMA   = 4'd6,
        TK_END     = 4'd7,
        TK_UNKNOWN = 4'd8
    } tok_kind_t;

    typedef enum logic [2:0] {
        OK_NUM  = 3'd0,
        OK_VAR  = 3'd1,
        OK_OPER = 3'd2,
        OK_FUNC = 3'd3,
        OK_END  = 3'd4
    } out_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_UNKNOWN  = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_UNBAL    = 2'd3
    } err_code_t;

    typedef enum logic [1:0] {
        ENT_PAREN = 2'd0,
        ENT_OPER  = 2'd1,
        ENT_FUNC  = 2'd2
    } ent_type_t;

    // operator stack entry
    typedef struct packed {
        ent_type_t          etype;
        logic [REF_W-1:0]   handle;
        logic [PREC_W-1:0]  prec;
        logic               la;
    } entry_t;

    // call frame: argument count and argument-seen flag
    typedef struct packed {
        logic [ARITY_W-1:0] count;
        logic               seen;
    } call_ent_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int CALL_W  = $bits(call_ent_t);

    typedef struct packed {
        out_kind_t          kind;
        logic [REF_W-1:0]   handle;
        logic [ARITY_W-1:0] arity;
        err_code_t          err;
    } res_t;

    // request from the sequencer to the output stage
    typedef struct packed {
        logic emit;
        logic fin;
        logic flush;
        res_t res;
    } emit_t;

    // answer from the output stage
    typedef struct packed {
        logic ok;
        logic pend_valid;
    } ostat_t;

endpackage

FILE: sv/shunting_yard_rpn_converter.sv
// infix to reverse polish converter, one token per item, stacks held in registered-read ram
// a token that pops nothing sends its result from the exec state into the output register; once
// an entry is popped, each result is held until the next one or the end of the token, then leaves
// through the output register; a new token is accepted only in idle, after exec and any close2,
// func2 or flush state; exec repeats for each stack entry popped, and output stalls hold it
// reset: async active low clears pointers, error flag and output stage; stack ram is kept
`include "shunting_yard_rpn_converter_macros.svh"

module shunting_yard_rpn_converter #(
    parameter int STACK_DEPTH = syr_pkg::STACK_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [3:0]                 token_kind,
    input  logic [syr_pkg::REF_W-1:0]  token_ref,
    input  logic [syr_pkg::PREC_W-1:0] op_precedence,
    input  logic                       op_left_assoc,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 out_kind,
    output logic [syr_pkg::REF_W-1:0]  out_ref,
    output logic [syr_pkg::ARITY_W-1:0] out_arity,
    output logic [1:0]                 out_error,
    output logic                       out_last
);
    import syr_pkg::*;

    localparam int IW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [ARITY_W-1:0] ARITY_MAX = '1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_CLOSE2 = 5'b00100,
        S_FUNC2  = 5'b01000,
        S_FLUSH  = 5'b10000
    } state_t;

    state_t state_reg, state_next, done_state;
    logic [PW-1:0] sp_reg, sp_next;
    logic [PW-1:0] csp_reg, csp_next;
    logic hold_reg, hold_next;
    err_code_t end_err_reg, end_err_next;
    tok_kind_t tok_kind_reg;
    logic [REF_W-1:0] tok_ref_reg;
    logic [PREC_W-1:0] tok_prec_reg;
    logic tok_la_reg;

    logic op_we, op_re;
    logic [IW-1:0] op_waddr, op_raddr;
    entry_t op_wdata;
    logic [ENTRY_W-1:0] op_rdata;
    logic call_we, call_re;
    logic [IW-1:0] call_waddr, call_raddr;
    call_ent_t call_wdata;
    logic [CALL_W-1:0] call_rdata;

    entry_t top_ent;
    call_ent_t ctop;
    logic [PW-1:0] sp_dec, csp_dec, sp_rd;
    logic sp_nz, csp_nz, sp_full, csp_full, in_fire, pops_oper;
    logic [ARITY_W-1:0] cnt_inc;
    emit_t emit_cmd;
    ostat_t ostat;
    res_t out_res;

    syr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STACK_DEPTH)
    ) u_op_ram (
        .clk  (clk),
        .we   (op_we),
        .waddr(op_waddr),
        .wdata(op_wdata),
        .re   (op_re),
        .raddr(op_raddr),
        .rdata(op_rdata)
    );

    syr_ram #(
        .WIDTH(CALL_W),
        .DEPTH(STACK_DEPTH)
    ) u_call_ram (
        .clk  (clk),
        .we   (call_we),
        .waddr(call_waddr),
        .wdata(call_wdata),
        .re   (call_re),
        .raddr(call_raddr),
        .rdata(call_rdata)
    );

    syr_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (emit_cmd),
        .status   (ostat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_res  (out_res),
        .out_last (out_last)
    );

    assign out_kind  = out_res.kind;
    assign out_ref   = out_res.handle;
    assign out_arity = out_res.arity;
    assign out_error = out_res.err;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign top_ent  = entry_t'(op_rdata);
    assign ctop     = call_ent_t'(call_rdata);
    assign sp_dec   = sp_reg - PW'(1);
    assign csp_dec  = csp_reg - PW'(1);
    assign sp_nz    = (sp_reg != '0);
    assign csp_nz   = (csp_reg != '0);
    assign sp_full  = (sp_reg >= PW'(STACK_DEPTH));
    assign csp_full = (csp_reg >= PW'(STACK_DEPTH));
    assign cnt_inc  = (ctop.seen && ctop.count != ARITY_MAX) ? ctop.count + ARITY_W'(1)
                                                             : ctop.count;
    assign pops_oper = sp_nz && (top_ent.etype == ENT_OPER) &&
                       ((top_ent.prec > tok_prec_reg) ||
                        ((top_ent.prec == tok_prec_reg) && tok_la_reg));

    // new top of stack is fetched from the pointer after update
    assign sp_rd      = sp_next - PW'(1);
    assign op_raddr   = sp_rd[IW-1:0];
    assign call_raddr = csp_dec[IW-1:0];
    assign call_re    = in_fire;
    assign done_state = ostat.pend_valid ? S_FLUSH : S_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        csp_next     = csp_reg;
        hold_next    = hold_reg;
        end_err_next = end_err_reg;
        op_we        = 1'b0;
        op_re        = in_fire;
        op_waddr     = sp_reg[IW-1:0];
        op_wdata     = '{etype: ENT_PAREN, handle: tok_ref_reg, prec: '0, la: 1'b0};
        call_we      = 1'b0;
        call_waddr   = csp_dec[IW-1:0];
        call_wdata   = '{count: ctop.count, seen: 1'b1};
        emit_cmd     = '0;
        emit_cmd.res = '{kind: OK_NUM, handle: tok_ref_reg, arity: '0, err: ERR_NONE};
        if (in_fire)
        begin
            end_err_next = ERR_NONE;
            state_next   = S_EXEC;
        end
        case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                if (tok_kind_reg == TK_END)
                begin
                    if (!hold_reg && sp_nz)
                    begin
                        if (top_ent.etype == ENT_OPER)
                        begin
                            emit_cmd.emit       = 1'b1;
                            emit_cmd.res.kind   = OK_OPER;
                            emit_cmd.res.handle = top_ent.handle;
                        end
                        else
                        begin
                            end_err_next = ERR_UNBAL;
                        end
                        if (ostat.ok)
                        begin
                            sp_next = sp_dec;
                            op_re   = 1'b1;
                        end
                    end
                    else
                    begin
                        emit_cmd.emit     = 1'b1;
                        emit_cmd.fin      = 1'b1;
                        emit_cmd.res.kind = OK_END;
                        emit_cmd.res.err  = hold_reg ? ERR_NONE : end_err_reg;
                        if (ostat.ok)
                        begin
                            sp_next    = '0;
                            csp_next   = '0;
                            hold_next  = 1'b0;
                            state_next = done_state;
                        end
                    end
                end
                else if (hold_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    case (tok_kind_reg)
                        TK_NUM, TK_VAR:
                        begin
                            emit_cmd.emit     = 1'b1;
                            emit_cmd.fin      = 1'b1;
                            emit_cmd.res.kind = (tok_kind_reg == TK_VAR) ? OK_VAR : OK_NUM;
                            if (ostat.ok)
                            begin
                                call_we    = csp_nz;
                                state_next = done_state;
                            end
                        end
                        TK_OPEN:
                        begin
                            if (sp_full)
                            begin
                                emit_cmd.emit    = 1'b1;
                                emit_cmd.fin     = 1'b1;
                                emit_cmd.res.err = ERR_OVERFLOW;
                                if (ostat.ok)
                                begin
                                    hold_next  = 1'b1;
                                    state_next = done_state;
                                end
                            end
                            else
                            begin
                                op_we      = 1'b1;
                                sp_next    = sp_reg + PW'(1);
                                state_next = done_state;
                            end
                        end
                        TK_OPER:
                        begin
                            if (pops_oper)
                            begin
                                emit_cmd.emit       = 1'b1;
                                emit_cmd.res.kind   = OK_OPER;
                                emit_cmd.res.handle = top_ent.handle;
                                if (ostat.ok)
                                begin
                                    sp_next = sp_dec;
                                    op_re   = 1'b1;
                                end
                            end
                            else if (sp_full)
                            begin
                                emit_cmd.emit    = 1'b1;
                                emit_cmd.fin     = 1'b1;
                                emit_cmd.res.err = ERR_OVERFLOW;
                                if (ostat.ok)
                                begin
                                    hold_next  = 1'b1;
                                    state_next = done_state;
                                end
                            end
                            else
                            begin
                                op_we      = 1'b1;
                                op_wdata   = '{etype: ENT_OPER, handle: tok_ref_reg,
                                               prec: tok_prec_reg, la: tok_la_reg};
                                sp_next    = sp_reg + PW'(1);
                                state_next = done_state;
                            end
                        end
                        TK_FUNC:
                        begin
                            if (sp_full || csp_full)
                            begin
                                emit_cmd.emit    = 1'b1;
                                emit_cmd.fin     = 1'b1;
                                emit_cmd.res.err = ERR_OVERFLOW;
                                if (ostat.ok)
                                begin
                                    hold_next  = 1'b1;
                                    state_next = done_state;
                                end
                            end
                            else
                            begin
                                call_we        = csp_nz;
                                op_we          = 1'b1;
                                op_wdata.etype = ENT_FUNC;
                                sp_next        = sp_reg + PW'(1);
                                state_next     = S_FUNC2;
                            end
                        end
                        TK_CLOSE, TK_COMMA:
                        begin
                            if (!sp_nz || ((top_ent.etype == ENT_PAREN) &&
                                           (tok_kind_reg == TK_COMMA) && !csp_nz))
                            begin
                                emit_cmd.emit    = 1'b1;
                                emit_cmd.fin     = 1'b1;
                                emit_cmd.res.err = ERR_UNBAL;
                                if (ostat.ok)
                                begin
                                    hold_next  = 1'b1;
                                    state_next = done_state;
                                end
                            end
                            else if (top_ent.etype == ENT_PAREN)
                            begin
                                if (tok_kind_reg == TK_CLOSE)
                                begin
                                    sp_next    = sp_dec;
                                    op_re      = 1'b1;
                                    state_next = S_CLOSE2;
                                end
                                else
                                begin
                                    call_we    = 1'b1;
                                    call_wdata = '{count: cnt_inc, seen: 1'b0};
                                    state_next = done_state;
                                end
                            end
                            else
                            begin
                                emit_cmd.emit       = 1'b1;
                                emit_cmd.res.kind   = (top_ent.etype == ENT_FUNC) ? OK_FUNC
                                                                                   : OK_OPER;
                                emit_cmd.res.handle = top_ent.handle;
                                if (ostat.ok)
                                begin
                                    sp_next = sp_dec;
                                    op_re   = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            emit_cmd.emit    = 1'b1;
                            emit_cmd.fin     = 1'b1;
                            emit_cmd.res.err = ERR_UNKNOWN;
                            if (ostat.ok)
                            begin
                                hold_next  = 1'b1;
                                state_next = done_state;
                            end
                        end
                    endcase
                end
            end
            S_CLOSE2:
            begin
                if (sp_nz && (top_ent.etype == ENT_FUNC))
                begin
                    emit_cmd.emit       = 1'b1;
                    emit_cmd.fin        = 1'b1;
                    emit_cmd.res.kind   = OK_FUNC;
                    emit_cmd.res.handle = top_ent.handle;
                    emit_cmd.res.arity  = csp_nz ? cnt_inc : '0;
                    if (ostat.ok)
                    begin
                        sp_next    = sp_dec;
                        csp_next   = csp_nz ? csp_dec : csp_reg;
                        state_next = done_state;
                    end
                end
                else
                begin
                    state_next = done_state;
                end
            end
            S_FUNC2:
            begin
                call_we    = 1'b1;
                call_waddr = csp_reg[IW-1:0];
                call_wdata = '{count: '0, seen: 1'b0};
                csp_next   = csp_reg + PW'(1);
                state_next = S_IDLE;
            end
            S_FLUSH:
            begin
                emit_cmd.flush = 1'b1;
                if (ostat.ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            csp_reg     <= '0;
            hold_reg    <= 1'b0;
            end_err_reg <= ERR_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            csp_reg     <= csp_next;
            hold_reg    <= hold_next;
            end_err_reg <= end_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tok_kind_reg <= tok_kind_t'(token_kind);
            tok_ref_reg  <= token_ref;
            tok_prec_reg <= op_precedence;
            tok_la_reg   <= op_left_assoc;
        end
    end

    `SYR_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == S_EXEC, "item not processed after accept")
    `SYR_ASSERT_HOLDS(a_ptr_range, (sp_reg <= PW'(STACK_DEPTH)) && (csp_reg <= PW'(STACK_DEPTH)), "stack pointer beyond depth")
    `SYR_ASSERT_NOW(a_idle_no_pend, state_reg == S_IDLE, !ostat.pend_valid, "held result left at idle")
    `SYR_ASSERT_NOW(a_flush_pend, emit_cmd.flush, ostat.pend_valid, "flush with nothing held")

endmodule

FILE: sv/syr_ram.sv
module syr_ram #(
    parameter int WIDTH = syr_pkg::ENTRY_W,
    parameter int DEPTH = syr_pkg::STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import syr_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/syr_out.sv
module syr_out (
    input  logic           clk,
    input  logic           rst_n,
    input  syr_pkg::emit_t cmd,
    output syr_pkg::ostat_t status,
    output logic           out_valid,
    input  logic           out_ready,
    output syr_pkg::res_t  out_res,
    output logic           out_last
);
    import syr_pkg::*;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;
    logic out_last_reg, out_last_next;
    logic pend_valid_reg, pend_valid_next;
    res_t pend_res_reg, pend_res_next;
    logic slot_free;
    logic load;

    assign slot_free = !out_valid_reg || out_ready;

    // one result is held back until it is known whether it ends the item
    always_comb
    begin
        load              = 1'b0;
        out_res_next      = out_res_reg;
        out_last_next     = out_last_reg;
        pend_valid_next   = pend_valid_reg;
        pend_res_next     = pend_res_reg;
        status.ok         = 1'b1;
        status.pend_valid = pend_valid_reg;
        if (cmd.emit)
        begin
            if (pend_valid_reg)
            begin
                status.ok = slot_free;
                if (slot_free)
                begin
                    load          = 1'b1;
                    out_res_next  = pend_res_reg;
                    out_last_next = 1'b0;
                    pend_res_next = cmd.res;
                end
            end
            else if (cmd.fin)
            begin
                status.ok = slot_free;
                if (slot_free)
                begin
                    load          = 1'b1;
                    out_res_next  = cmd.res;
                    out_last_next = 1'b1;
                end
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_res_next   = cmd.res;
            end
        end
        else if (cmd.flush)
        begin
            status.ok = slot_free;
            if (slot_free)
            begin
                load            = 1'b1;
                out_res_next    = pend_res_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: dv/rpn_order_checker.sv
module rpn_order_checker
    import syr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [3:0]          token_kind,
    input  logic [REF_W-1:0]    token_ref,
    input  logic [PREC_W-1:0]   op_precedence,
    input  logic                op_left_assoc,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [2:0]          out_kind,
    input  logic [REF_W-1:0]    out_ref,
    input  logic [ARITY_W-1:0]  out_arity,
    input  logic [1:0]          out_error,
    input  logic                out_last,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam logic [ARITY_W-1:0] ARITY_MAX = '1;

    typedef struct packed {
        out_kind_t          kind;
        logic [REF_W-1:0]   handle;
        logic [ARITY_W-1:0] arity;
        err_code_t          err;
        logic               last;
    } rpn_token_t;

    entry_t             op_stk [STACK_DEPTH];
    logic [ARITY_W-1:0] arg_cnt [STACK_DEPTH];
    bit                 arg_seen [STACK_DEPTH];
    int                 op_sp;
    int                 call_sp;
    bit                 err_hold;

    rpn_token_t step_res [$];
    rpn_token_t rpn_expected [$];
    rpn_token_t got_tok;
    rpn_token_t exp_tok;
    int         fail_cnt = 0;

    function automatic void push_res(input out_kind_t kind, input logic [REF_W-1:0] handle,
                                     input logic [ARITY_W-1:0] arity, input err_code_t err);
        rpn_token_t t;
        t.kind = kind;
        t.handle = handle;
        t.arity = arity;
        t.err = err;
        t.last = 1'b0;
        step_res = {step_res, t};
    endfunction

    function automatic void raise_err(input logic [REF_W-1:0] handle, input err_code_t err);
        push_res(OK_NUM, handle, '0, err);
        err_hold = 1'b1;
    endfunction

    function automatic void mark_seen();
        if (call_sp > 0 && call_sp <= STACK_DEPTH)
            arg_seen[call_sp-1] = 1'b1;
    endfunction

    // pop operators and functions down to the nearest open paren
    function automatic bit flush_to_paren();
        entry_t e;
        while (op_sp > 0)
        begin
            e = op_stk[op_sp-1];
            if (e.etype == ENT_PAREN)
                return 1'b1;
            push_res(e.etype == ENT_FUNC ? OK_FUNC : OK_OPER, e.handle, '0, ERR_NONE);
            op_sp--;
        end
        return 1'b0;
    endfunction

    function automatic void convert_token(input logic [3:0] kind,
                                          input logic [REF_W-1:0] handle,
                                          input logic [PREC_W-1:0] prec, input logic la);
        entry_t             e;
        err_code_t          err;
        logic [ARITY_W-1:0] a;
        bit                 found;
        int                 t;
        step_res.delete();
        if (kind == TK_END)
        begin
            err = ERR_NONE;
            if (!err_hold)
            begin
                while (op_sp > 0)
                begin
                    e = op_stk[op_sp-1];
                    if (e.etype == ENT_OPER)
                        push_res(OK_OPER, e.handle, '0, ERR_NONE);
                    else
                        err = ERR_UNBAL;
                    op_sp--;
                end
            end
            push_res(OK_END, handle, '0, err);
            op_sp = 0;
            call_sp = 0;
            err_hold = 1'b0;
        end
        else if (!err_hold)
        begin
            case (kind)
                TK_NUM:
                begin
                    push_res(OK_NUM, handle, '0, ERR_NONE);
                    mark_seen();
                end
                TK_VAR:
                begin
                    push_res(OK_VAR, handle, '0, ERR_NONE);
                    mark_seen();
                end
                TK_OPEN:
                begin
                    if (op_sp >= STACK_DEPTH)
                        raise_err(handle, ERR_OVERFLOW);
                    else
                    begin
                        e.etype = ENT_PAREN;
                        e.handle = handle;
                        e.prec = '0;
                        e.la = 1'b0;
                        op_stk[op_sp] = e;
                        op_sp++;
                    end
                end
                TK_OPER:
                begin
                    while (op_sp > 0)
                    begin
                        e = op_stk[op_sp-1];
                        if (e.etype != ENT_OPER)
                            break;
                        if (e.prec > prec || (e.prec == prec && la))
                        begin
                            push_res(OK_OPER, e.handle, '0, ERR_NONE);
                            op_sp--;
                        end
                        else
                            break;
                    end
                    if (op_sp >= STACK_DEPTH)
                        raise_err(handle, ERR_OVERFLOW);
                    else
                    begin
                        e.etype = ENT_OPER;
                        e.handle = handle;
                        e.prec = prec;
                        e.la = la;
                        op_stk[op_sp] = e;
                        op_sp++;
                    end
                end
                TK_FUNC:
                begin
                    if (op_sp >= STACK_DEPTH || call_sp >= STACK_DEPTH)
                        raise_err(handle, ERR_OVERFLOW);
                    else
                    begin
                        mark_seen();
                        e.etype = ENT_FUNC;
                        e.handle = handle;
                        e.prec = '0;
                        e.la = 1'b0;
                        op_stk[op_sp] = e;
                        op_sp++;
                        arg_cnt[call_sp] = '0;
                        arg_seen[call_sp] = 1'b0;
                        call_sp++;
                    end
                end
                TK_CLOSE:
                begin
                    found = flush_to_paren();
                    if (!found)
                        raise_err(handle, ERR_UNBAL);
                    else
                    begin
                        op_sp--;
                        if (op_sp > 0 && op_stk[op_sp-1].etype == ENT_FUNC)
                        begin
                            e = op_stk[op_sp-1];
                            a = '0;
                            if (call_sp > 0)
                            begin
                                call_sp--;
                                a = arg_cnt[call_sp];
                                if (arg_seen[call_sp] && a < ARITY_MAX)
                                    a = a + 1'b1;
                            end
                            push_res(OK_FUNC, e.handle, a, ERR_NONE);
                            op_sp--;
                        end
                    end
                end
                TK_COMMA:
                begin
                    found = flush_to_paren();
                    if (!found || call_sp == 0)
                        raise_err(handle, ERR_UNBAL);
                    else
                    begin
                        t = call_sp - 1;
                        if (arg_seen[t] && arg_cnt[t] < ARITY_MAX)
                            arg_cnt[t] = arg_cnt[t] + 1'b1;
                        arg_seen[t] = 1'b0;
                    end
                end
                default:
                    raise_err(handle, ERR_UNKNOWN);
            endcase
        end
        foreach (step_res[i])
        begin
            if (i == step_res.size() - 1)
                step_res[i].last = 1'b1;
            rpn_expected = {rpn_expected, step_res[i]};
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_sp = 0;
            call_sp = 0;
            err_hold = 1'b0;
            rpn_expected.delete();
        end
        else
        begin
            // results are matched before the new item is predicted
            if (out_valid && out_ready)
            begin
                got_tok.kind = out_kind_t'(out_kind);
                got_tok.handle = out_ref;
                got_tok.arity = out_arity;
                got_tok.err = err_code_t'(out_error);
                got_tok.last = out_last;
                if (rpn_expected.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("unexpected result: kind %0d ref %h arity %0d err %0d last %0d",
                                 out_kind, out_ref, out_arity, out_error, out_last);
                    fail_cnt++;
                end
                else
                begin
                    exp_tok = rpn_expected.pop_front();
                    if (got_tok.kind !== exp_tok.kind || got_tok.handle !== exp_tok.handle ||
                        got_tok.arity !== exp_tok.arity || got_tok.err !== exp_tok.err ||
                        got_tok.last !== exp_tok.last)
                    begin
                        if (fail_cnt < 10)
                            $display({"mismatch: expected kind %0d ref %h arity %0d err %0d ",
                                      "last %0d, got kind %0d ref %h arity %0d err %0d last %0d"},
                                     exp_tok.kind, exp_tok.handle, exp_tok.arity, exp_tok.err,
                                     exp_tok.last, out_kind, out_ref, out_arity, out_error,
                                     out_last);
                        fail_cnt++;
                    end
                end
            end
            if (in_valid && in_ready)
                convert_token(token_kind, token_ref, op_precedence, op_left_assoc);
        end
        pending <= rpn_expected.size();
        fail_count <= fail_cnt;
    end

endmodule

FILE: dv/tb_shunting_yard_rpn_converter.sv
module tb_shunting_yard_rpn_converter;
    import syr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEMS_PER_PHASE = 6;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [3:0]          token_kind = '0;
    logic [REF_W-1:0]    token_ref = '0;
    logic [PREC_W-1:0]   op_precedence = '0;
    logic                op_left_assoc = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2:0]          out_kind;
    logic [REF_W-1:0]    out_ref;
    logic [ARITY_W-1:0]  out_arity;
    logic [1:0]          out_error;
    logic                out_last;
    int                  fail_count;
    int                  pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    shunting_yard_rpn_converter uut (.*);

    rpn_order_checker u_checker (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_token(input logic [3:0] kind, input logic [REF_W-1:0] handle,
                              input logic [PREC_W-1:0] prec, input logic la);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        token_kind <= kind;
        token_ref <= handle;
        op_precedence <= prec;
        op_left_assoc <= la;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_kind(input logic [3:0] kind);
        send_token(kind, REF_W'($urandom_range(65535)), PREC_W'($urandom_range(3)),
                   1'($urandom_range(1)));
    endtask

    task automatic send_operand();
        send_kind($urandom_range(1) ? TK_NUM : TK_VAR);
    endtask

    // well formed infix with nested parens and calls, with noise tokens mixed in at noise_pct percent
    task automatic gen_sequence(input int noise_pct);
        int budget;
        int nest;
        int pick;
        bit want_operand;
        bit frame_call [8];
        budget = $urandom_range(14, 3);
        nest = 0;
        want_operand = 1'b1;
        for (int i = 0; i < budget; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_kind(4'($urandom_range(15)));
            else if (want_operand)
            begin
                pick = $urandom_range(9);
                if (pick < 5 || nest == 8)
                begin
                    send_operand();
                    want_operand = 1'b0;
                end
                else if (pick < 7)
                begin
                    send_kind(TK_OPEN);
                    frame_call[nest] = 1'b0;
                    nest++;
                end
                else
                begin
                    send_kind(TK_FUNC);
                    send_kind(TK_OPEN);
                    frame_call[nest] = 1'b1;
                    nest++;
                    if ($urandom_range(3) == 0)
                    begin
                        send_kind(TK_CLOSE);
                        nest--;
                        want_operand = 1'b0;
                    end
                end
            end
            else
            begin
                pick = $urandom_range(9);
                if (nest > 0 && pick >= 7)
                begin
                    send_kind(TK_CLOSE);
                    nest--;
                end
                else if (nest > 0 && frame_call[nest-1] && pick >= 5)
                begin
                    send_kind(TK_COMMA);
                    want_operand = 1'b1;
                end
                else
                begin
                    send_kind(TK_OPER);
                    want_operand = 1'b1;
                end
            end
        end
        if (want_operand)
            send_operand();
        while (nest > 0)
        begin
            send_kind(TK_CLOSE);
            nest--;
        end
        send_kind(TK_END);
    endtask

    initial
    begin
        int phase_start;
        int pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operator precedence and associativity pops
        send_token(TK_NUM, 16'h0000, 2'd0, 1'b0);
        send_token(TK_OPER, 16'h0001, 2'd1, 1'b1);
        send_token(TK_VAR, 16'hffff, 2'd3, 1'b1);
        send_token(TK_OPER, 16'h0002, 2'd2, 1'b1);
        send_token(TK_NUM, 16'h0003, 2'd0, 1'b0);
        send_token(TK_OPER, 16'h0004, 2'd1, 1'b1);
        send_token(TK_NUM, 16'h0005, 2'd0, 1'b0);
        send_token(TK_END, 16'hffff, 2'd0, 1'b0);
        // call with two arguments
        send_token(TK_FUNC, 16'h0010, 2'd0, 1'b0);
        send_token(TK_OPEN, 16'h0011, 2'd0, 1'b0);
        send_token(TK_NUM, 16'h0012, 2'd0, 1'b0);
        send_token(TK_COMMA, 16'h0013, 2'd0, 1'b0);
        send_token(TK_VAR, 16'h0014, 2'd0, 1'b0);
        send_token(TK_CLOSE, 16'h0015, 2'd0, 1'b0);
        send_token(TK_END, 16'h0000, 2'd0, 1'b0);
        // close paren with no open paren, then tokens dropped until end
        send_token(TK_CLOSE, 16'h0020, 2'd0, 1'b0);
        send_token(TK_NUM, 16'h0021, 2'd0, 1'b0);
        send_token(TK_END, 16'h0022, 2'd0, 1'b0);
        // comma outside any call
        send_token(TK_OPEN, 16'h0030, 2'd0, 1'b0);
        send_token(TK_COMMA, 16'h0031, 2'd0, 1'b0);
        send_token(TK_END, 16'h0032, 2'd0, 1'b0);
        send_token(TK_UNKNOWN, 16'h0040, 2'd3, 1'b1);
        send_token(TK_END, 16'h0041, 2'd0, 1'b0);
        // end with an open paren still stacked
        send_token(TK_OPEN, 16'h0050, 2'd0, 1'b0);
        send_token(TK_END, 16'h0051, 2'd0, 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            case (phase)
                0:
                begin
                    // call with three arguments
                    send_kind(TK_FUNC);
                    send_kind(TK_OPEN);
                    send_operand();
                    repeat (2)
                    begin
                        send_kind(TK_COMMA);
                        send_operand();
                    end
                    send_kind(TK_CLOSE);
                    send_kind(TK_END);
                end
                1:
                begin
                    repeat (33) send_kind(TK_OPEN);
                    send_kind(TK_END);
                end
                2:
                begin
                    // right associative operators, end pops them all
                    send_operand();
                    repeat (3)
                    begin
                        send_token(TK_OPER, REF_W'($urandom_range(65535)), 2'd3, 1'b0);
                        send_operand();
                    end
                    send_kind(TK_END);
                end
                default:
                begin
                    // functions left on the stack at end
                    repeat (4) send_kind(TK_FUNC);
                    send_kind(TK_END);
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(9);
                if (pick < 7)
                    gen_sequence(0);
                else if (pick < 9)
                    gen_sequence(15);
                else
                    gen_sequence(100);
            end
        end

        in_valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/syr_pkg.sv
sv/syr_ram.sv
sv/syr_out.sv
sv/shunting_yard_rpn_converter.sv
dv/rpn_order_checker.sv
dv/tb_shunting_yard_rpn_converter.sv
